// ===== design/subarray_or_coverage_scorer_defines.svh =====
// Assertion macros used by the scorer top level.
`ifndef SUBARRAY_OR_COVERAGE_SCORER_DEFINES_SVH
`define SUBARRAY_OR_COVERAGE_SCORER_DEFINES_SVH

// Check a same-cycle implication on i_clk, masked during reset.
`define SOC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication on i_clk, masked during reset.
`define SOC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/soc_pkg.sv =====
// Shared constants, word types and helper function of the subarray OR scorer.
package soc_pkg;

    localparam int MAX_BITS    = 16;
    localparam int TAG_BITS    = 16;
    localparam int CHAIN_DEPTH = MAX_BITS + 1;
    localparam int IDX_W       = $clog2(CHAIN_DEPTH + 1);
    localparam int STORE_DEPTH = 1 << MAX_BITS;
    localparam int ADDR_W      = MAX_BITS;
    localparam int SCORE_W     = 26;
    localparam int WGT_W       = 8;
    localparam int K_W         = 5;
    localparam int POP_W       = $clog2(MAX_BITS + 1);
    localparam int ADD_W       = WGT_W + 1;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR      = 2'd2;

    // Register reset values
    localparam logic [K_W-1:0]   BIT_COUNT_RST = 5'd6;
    localparam logic [WGT_W-1:0] CENTRAL_RST   = 8'd100;
    localparam logic [WGT_W-1:0] NEAR_RST      = 8'd8;

    typedef struct packed {
        logic [15:0] mask_value;
        logic        first_item;
    } t_in_word;

    typedef struct packed {
        logic [25:0] running_score;
        logic [4:0]  chain_length;
    } t_out_word;

    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [WGT_W-1:0] central_weight;
        logic [WGT_W-1:0] near_weight;
    } t_cfg;

    // Control broadcast to every chain cell
    typedef struct packed {
        logic                shift;
        logic                wr_en;
        logic [IDX_W-1:0]    wr_idx;
        logic [MAX_BITS-1:0] wr_data;
    } t_cell_ctl;

    // Tag store clearing sweep
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_clr;

    function automatic logic [POP_W-1:0] popcount(input logic [MAX_BITS-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int b = 0; b < MAX_BITS; b++) begin
            n = n + POP_W'(v[b]);
        end
        return n;
    endfunction

endpackage

// ===== design/soc_cell.sv =====
// One cell of the OR chain: holds one entry, loads by index or from its neighbor.
module soc_cell (
    input  logic                          i_clk,
    input  soc_pkg::t_cell_ctl            i_ctl,
    input  logic [soc_pkg::IDX_W-1:0]     i_idx,
    input  logic [soc_pkg::MAX_BITS-1:0]  i_nbr,
    output logic [soc_pkg::MAX_BITS-1:0]  o_val
);

    logic [soc_pkg::MAX_BITS-1:0] r_val;

    // Take a targeted write first, else advance from the neighbor, else hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_idx == i_idx) begin
            r_val <= i_ctl.wr_data;
        end else if (i_ctl.shift) begin
            r_val <= i_nbr;
        end
    end

    assign o_val = r_val;

endmodule

// ===== design/soc_chain.sv =====
// Row of chain cells that shifts toward the head and presents cell 0.
module soc_chain (
    input  logic                          i_clk,
    input  soc_pkg::t_cell_ctl            i_ctl,
    output logic [soc_pkg::MAX_BITS-1:0]  o_head
);

    logic [soc_pkg::MAX_BITS-1:0] w_val [soc_pkg::CHAIN_DEPTH];

    for (genvar g = 0; g < soc_pkg::CHAIN_DEPTH; g++) begin : g_cell
        logic [soc_pkg::MAX_BITS-1:0] w_nbr;

        // Tail cell fills with zero
        if (g == soc_pkg::CHAIN_DEPTH - 1) begin : g_tail
            assign w_nbr = '0;
        end else begin : g_body
            assign w_nbr = w_val[g+1];
        end

        soc_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (i_ctl),
            .i_idx (soc_pkg::IDX_W'(g)),
            .i_nbr (w_nbr),
            .o_val (w_val[g])
        );
    end

    assign o_head = w_val[0];

endmodule

// ===== design/soc_tag_ram.sv =====
// Tag store: one epoch mark per mask value, one write and one registered read a cycle.
module soc_tag_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [soc_pkg::ADDR_W-1:0]    i_waddr,
    input  logic [soc_pkg::TAG_BITS-1:0]  i_wdata,
    input  logic [soc_pkg::ADDR_W-1:0]    i_raddr,
    output logic [soc_pkg::TAG_BITS-1:0]  o_rdata
);

    logic [soc_pkg::TAG_BITS-1:0] r_mem [soc_pkg::STORE_DEPTH];
    logic [soc_pkg::TAG_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/soc_scorer.sv =====
// Scoring pipeline: tag lookup, layer weighting and saturating score accumulation.
module soc_scorer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  soc_pkg::t_cfg                 i_cfg,
    input  logic [soc_pkg::TAG_BITS-1:0]  i_epoch,
    input  soc_pkg::t_clr                 i_clr,
    input  logic                          i_score_clr,
    input  logic                          i_elem_vld,
    input  logic [soc_pkg::MAX_BITS-1:0]  i_elem,
    output logic                          o_busy,
    output logic [soc_pkg::SCORE_W-1:0]   o_score
);

    logic                          r_a_vld;
    logic [soc_pkg::MAX_BITS-1:0]  r_a_m;
    logic [soc_pkg::POP_W-1:0]     r_a_pop;
    logic                          r_w_vld;
    logic [soc_pkg::ADDR_W-1:0]    r_w_addr;
    logic                          r_b_vld;
    logic [soc_pkg::ADD_W-1:0]     r_b_add;
    logic [soc_pkg::SCORE_W-1:0]   r_score;

    logic [soc_pkg::TAG_BITS-1:0]  w_rdata;
    logic                          w_seen;
    logic                          w_hit;
    logic                          w_we;
    logic [soc_pkg::ADDR_W-1:0]    w_waddr;
    logic [soc_pkg::TAG_BITS-1:0]  w_wdata;
    logic [5:0]                    w_p6;
    logic [5:0]                    w_h6;
    logic [5:0]                    w_k6;
    logic                          w_central;
    logic                          w_near;
    logic [soc_pkg::ADD_W-1:0]     w_add;
    logic [soc_pkg::SCORE_W:0]     w_sum;

    soc_tag_ram u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_elem),
        .o_rdata (w_rdata)
    );

    // Stage A: issue the tag read, count ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_elem_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_m   <= i_elem;
        r_a_pop <= soc_pkg::popcount(i_elem);
    end

    // Stage B: a mask is new unless its tag matches or it was just marked
    assign w_seen = (w_rdata == i_epoch) || (r_w_vld && r_w_addr == r_a_m);
    assign w_hit  = r_a_vld && (r_a_m != '0) && !w_seen;

    // Mark new masks; the clearing sweep owns the write port when active
    assign w_we    = i_clr.en || w_hit;
    assign w_waddr = i_clr.en ? i_clr.addr : r_a_m;
    assign w_wdata = i_clr.en ? '0 : i_epoch;

    // Layer test against the middle popcount layers
    assign w_p6      = {1'b0, r_a_pop};
    assign w_k6      = {1'b0, i_cfg.k};
    assign w_h6      = {1'b0, 1'b0, i_cfg.k[soc_pkg::K_W-1:1]};
    assign w_central = (w_p6 == w_h6) || (i_cfg.k[0] && w_p6 == w_h6 + 6'd1);
    assign w_near    = (w_p6 + 6'd1 == w_h6) || (w_p6 == w_k6 - w_h6 + 6'd1);
    assign w_add     = soc_pkg::ADD_W'(1)
                     + (w_central ? {1'b0, i_cfg.central_weight} : '0)
                     + (w_near ? {1'b0, i_cfg.near_weight} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_w_vld <= 1'b0;
        end else begin
            r_b_vld <= w_hit;
            r_w_vld <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_add  <= w_add;
        r_w_addr <= r_a_m;
    end

    // Stage C: accumulate with saturation
    assign w_sum = {1'b0, r_score} + (soc_pkg::SCORE_W + 1)'(r_b_add);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0;
        end else if (i_score_clr) begin
            r_score <= '0;
        end else if (r_b_vld) begin
            r_score <= w_sum[soc_pkg::SCORE_W] ? soc_pkg::SCORE_MAX
                                               : w_sum[soc_pkg::SCORE_W-1:0];
        end
    end

    assign o_busy  = r_a_vld || r_b_vld;
    assign o_score = r_score;

endmodule

// ===== design/subarray_or_coverage_scorer.sv =====
// Top level of the subarray OR coverage scorer.
// Each input word carries one mask; the block keeps the distinct ORs of all
// subarrays ending at the latest mask in a row of 17 cells and scores every
// nonzero OR value not yet seen in the current sequence, returning one word
// per item with the running score and the new chain length. For each item
// the chain left by the previous item (empty at a sequence start, at most
// 17 entries) is walked one entry a cycle through a single read-then-mark
// port of the 65536-entry tag store, followed by the three stage scoring
// pipeline draining. One item is in flight at a time. After reset, and
// whenever the 16-bit sequence epoch wraps, the tag store is cleared one
// entry a cycle, during which no input word is taken; configuration
// writes are always taken.
`include "subarray_or_coverage_scorer_defines.svh"

module subarray_or_coverage_scorer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  soc_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output soc_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [soc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [soc_pkg::WGT_W-1:0]       i_cfg_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;

    localparam int MB = soc_pkg::MAX_BITS;
    localparam int IW = soc_pkg::IDX_W;

    logic [2:0]                    r_state,     n_state;
    logic [soc_pkg::K_W-1:0]       r_bit_count;
    logic [soc_pkg::WGT_W-1:0]     r_cw;
    logic [soc_pkg::WGT_W-1:0]     r_nw;
    logic [soc_pkg::TAG_BITS-1:0]  r_epoch,     n_epoch;
    logic [soc_pkg::ADDR_W-1:0]    r_clr_addr,  n_clr_addr;
    logic                          r_resume,    n_resume;
    logic [MB-1:0]                 r_v,         n_v;
    logic [IW-1:0]                 r_size,      n_size;
    logic [IW-1:0]                 r_old,       n_old;
    logic [IW-1:0]                 r_step,      n_step;
    logic [IW-1:0]                 r_q,         n_q;
    logic [MB-1:0]                 r_pend,      n_pend;
    logic                          r_out_vld,   n_out_vld;
    soc_pkg::t_out_word            r_out_word,  n_out_word;

    logic [soc_pkg::K_W-1:0]       w_k;
    logic [MB:0]                   w_kmask_w;
    logic [MB-1:0]                 w_kmask;
    logic                          w_accept;
    logic                          w_start;
    logic [soc_pkg::TAG_BITS-1:0]  w_epoch_inc;
    logic [MB-1:0]                 w_head;
    logic [MB-1:0]                 w_x;
    logic                          w_first;
    logic                          w_pop_step;
    logic                          w_last_step;
    logic                          w_new;
    logic                          w_walk;
    logic                          w_busy;
    logic [soc_pkg::SCORE_W-1:0]   w_score;
    logic                          w_score_clr;
    logic                          w_elem_vld;
    logic [MB-1:0]                 w_elem;
    soc_pkg::t_cell_ctl            w_ctl;
    soc_pkg::t_cfg                 w_cfg;
    soc_pkg::t_clr                 w_clr;

    // Configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= soc_pkg::BIT_COUNT_RST;
            r_cw        <= soc_pkg::CENTRAL_RST;
            r_nw        <= soc_pkg::NEAR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                soc_pkg::CFG_BIT_COUNT: r_bit_count <= i_cfg_data[soc_pkg::K_W-1:0];
                soc_pkg::CFG_CENTRAL:   r_cw        <= i_cfg_data;
                soc_pkg::CFG_NEAR:      r_nw        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the mask width and build the input mask
    assign w_k       = (r_bit_count > soc_pkg::K_W'(MB)) ? soc_pkg::K_W'(MB) : r_bit_count;
    assign w_kmask_w = ((MB + 1)'(1) << w_k) - (MB + 1)'(1);
    assign w_kmask   = w_kmask_w[MB-1:0];

    assign w_cfg.k              = w_k;
    assign w_cfg.central_weight = r_cw;
    assign w_cfg.near_weight    = r_nw;

    // Input handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_start     = i_in_word.first_item || (r_epoch == '0);
    assign w_epoch_inc = r_epoch + soc_pkg::TAG_BITS'(1);
    assign w_score_clr = w_accept && w_start;

    // Chain walk: step 0 takes the new mask, steps 1..L pop old entries,
    // step L+1 stores the last pending entry
    assign w_walk      = (r_state == S_WALK);
    assign w_x         = w_head | r_v;
    assign w_first     = (r_step == '0);
    assign w_pop_step  = !w_first && (r_step <= r_old);
    assign w_last_step = (r_step == r_old + IW'(1));
    assign w_new       = w_pop_step && (w_x != r_pend);

    assign w_ctl.shift   = w_walk && w_pop_step;
    assign w_ctl.wr_en   = w_walk && (w_new || w_last_step);
    assign w_ctl.wr_idx  = w_last_step ? r_q : (r_old - r_step + r_q);
    assign w_ctl.wr_data = r_pend;

    assign w_elem_vld = w_walk && (w_first || w_new);
    assign w_elem     = w_first ? r_v : w_x;

    assign w_clr.en   = (r_state == S_CLEAR);
    assign w_clr.addr = r_clr_addr;

    soc_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    soc_scorer u_scorer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_epoch     (r_epoch),
        .i_clr       (w_clr),
        .i_score_clr (w_score_clr),
        .i_elem_vld  (w_elem_vld),
        .i_elem      (w_elem),
        .o_busy      (w_busy),
        .o_score     (w_score)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_epoch    = r_epoch;
        n_clr_addr = r_clr_addr;
        n_resume   = r_resume;
        n_v        = r_v;
        n_size     = r_size;
        n_old      = r_old;
        n_step     = r_step;
        n_q        = r_q;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld;
        n_out_word = r_out_word;

        // Drop the output word once taken
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + soc_pkg::ADDR_W'(1);
                if (r_clr_addr == soc_pkg::ADDR_W'(soc_pkg::STORE_DEPTH - 1)) begin
                    if (r_resume) begin
                        n_epoch  = soc_pkg::TAG_BITS'(1);
                        n_resume = 1'b0;
                        n_state  = S_WALK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_v    = i_in_word.mask_value & w_kmask;
                    n_old  = w_start ? '0 : r_size;
                    n_step = '0;
                    n_q    = '0;
                    n_state = S_WALK;
                    if (w_start) begin
                        n_epoch = w_epoch_inc;
                        if (w_epoch_inc == '0) begin
                            n_clr_addr = '0;
                            n_resume   = 1'b1;
                            n_state    = S_CLEAR;
                        end
                    end
                end
            end
            S_WALK: begin
                n_step = r_step + IW'(1);
                if (w_first) begin
                    n_pend = r_v;
                end else if (w_new) begin
                    n_pend = w_x;
                    n_q    = r_q + IW'(1);
                end
                if (w_last_step) begin
                    n_size  = r_q + IW'(1);
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_busy && (!r_out_vld || !i_out_stall)) begin
                    n_out_vld                  = 1'b1;
                    n_out_word.running_score   = w_score;
                    n_out_word.chain_length    = r_size;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_epoch    <= '0;
            r_clr_addr <= '0;
            r_resume   <= 1'b0;
            r_size     <= '0;
            r_old      <= '0;
            r_step     <= '0;
            r_q        <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_epoch    <= n_epoch;
            r_clr_addr <= n_clr_addr;
            r_resume   <= n_resume;
            r_size     <= n_size;
            r_old      <= n_old;
            r_step     <= n_step;
            r_q        <= n_q;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_pend     <= n_pend;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // Chain never grows past its cell count
    `SOC_ASSERT_IMP(a_size_bound, 1'b1, r_size <= IW'(soc_pkg::CHAIN_DEPTH), "chain size exceeds cell count")
    // Writes into the chain always land on a real cell
    `SOC_ASSERT_IMP(a_wr_idx_range, w_ctl.wr_en, w_ctl.wr_idx < IW'(soc_pkg::CHAIN_DEPTH), "chain write index out of range")
    // Scoring only runs with an open sequence epoch
    `SOC_ASSERT_IMP(a_walk_epoch, r_state == S_WALK, r_epoch != '0, "walk with zero epoch")
    // An accepted word starts a walk or a clearing sweep
    `SOC_ASSERT_NXT(a_accept_go, w_accept, r_state == S_WALK || r_state == S_CLEAR, "accepted word not started")

endmodule

// ===== dv/subarray_or_coverage_scorer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the subarray OR coverage scorer with a built-in score predictor.
module subarray_or_coverage_scorer_tb;

    localparam logic [soc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 24;
    localparam int PHASE_ITEMS   = 75;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    soc_pkg::t_in_word             i_in_word   = '0;
    logic                          i_out_stall = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [soc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [soc_pkg::WGT_W-1:0]     i_cfg_data  = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    soc_pkg::t_out_word            o_out_word;
    logic                          o_cfg_ready;

    // Predictor state: settings, OR chain, tag store, epoch and score
    soc_pkg::t_cfg cur_cfg = {soc_pkg::BIT_COUNT_RST, soc_pkg::CENTRAL_RST,
                              soc_pkg::NEAR_RST};
    bit [15:0]     seq_chain [soc_pkg::CHAIN_DEPTH];
    int unsigned   seq_chain_len = 0;
    bit [15:0]     tag_epoch [soc_pkg::STORE_DEPTH];
    bit [15:0]     seq_epoch = '0;
    int unsigned   seq_score = 0;

    soc_pkg::t_out_word score_queue [$];
    int                 fail_count = 0;
    bit                 idle_on = 1'b1;
    bit                 hold_req = 1'b0;

    subarray_or_coverage_scorer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_width();
        return (cur_cfg.k > soc_pkg::MAX_BITS) ? soc_pkg::MAX_BITS : int'(cur_cfg.k);
    endfunction

    // Advance the predictor by one mask and return the expected result word
    function automatic soc_pkg::t_out_word score_mask(input soc_pkg::t_in_word w);
        int unsigned        k, half, r, n, add;
        bit [15:0]          v, x;
        bit [15:0]          nxt [soc_pkg::CHAIN_DEPTH];
        bit                 central, near_c;
        soc_pkg::t_out_word res;
        k    = eff_width();
        v    = w.mask_value & 16'((32'd1 << k) - 1);
        half = k / 2;
        // Open a new sequence, clearing the tags when the epoch wraps
        if (w.first_item || seq_epoch == 0) begin
            seq_epoch = seq_epoch + 1'b1;
            if (seq_epoch == 0) begin
                foreach (tag_epoch[j]) tag_epoch[j] = '0;
                seq_epoch = 16'd1;
            end
            seq_chain_len = 0;
            seq_score     = 0;
        end
        // Build the chain of distinct ORs ending at this mask
        nxt[0] = v;
        n      = 1;
        for (int i = 0; i < seq_chain_len; i++) begin
            x = seq_chain[i] | v;
            if (x != nxt[n-1] && n < soc_pkg::CHAIN_DEPTH) begin
                nxt[n] = x;
                n++;
            end
        end
        // Score every nonzero OR not yet seen in this sequence
        for (int i = 0; i < n; i++) begin
            if (nxt[i] != 0 && tag_epoch[nxt[i]] != seq_epoch) begin
                r       = $countones(nxt[i]);
                central = (r == half) || ((k % 2 == 1) && r == half + 1);
                near_c  = (r + 1 == half) || (r == k - half + 1);
                tag_epoch[nxt[i]] = seq_epoch;
                add = 1;
                if (central) add += cur_cfg.central_weight;
                if (near_c) add += cur_cfg.near_weight;
                seq_score += add;
                if (seq_score > soc_pkg::SCORE_MAX) seq_score = soc_pkg::SCORE_MAX;
            end
        end
        for (int i = 0; i < n; i++) seq_chain[i] = nxt[i];
        seq_chain_len = n;
        res.running_score = seq_score[25:0];
        res.chain_length  = n[4:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_mask(input int k);
        logic [15:0] m;
        case ($urandom_range(0, 11))
            0, 1, 2: m = (k > 0) ? 16'd1 << $urandom_range(0, k - 1)
                                 : 16'd1 << $urandom_range(0, 15);
            3:       m = 16'd1 << $urandom_range(0, 15);
            4, 5:    m = 16'($urandom & $urandom);
            6:       m = 16'($urandom & $urandom & $urandom);
            7, 8, 9: m = 16'($urandom);
            10:      m = '0;
            default: m = 16'hFFFF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one word and record its expected result once taken
    task automatic send_item(input logic start_seq, input logic [15:0] mask);
        int                 gap;
        soc_pkg::t_in_word  w;
        soc_pkg::t_out_word exp_word;
        w.mask_value = mask;
        w.first_item = start_seq;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        exp_word = score_mask(w);
        score_queue.insert(score_queue.size(), exp_word);
    endtask

    // Hold the input until every result is back, then let the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (score_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [soc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [soc_pkg::WGT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            soc_pkg::CFG_BIT_COUNT: cur_cfg.k              = data[soc_pkg::K_W-1:0];
            soc_pkg::CFG_CENTRAL:   cur_cfg.central_weight = data;
            soc_pkg::CFG_NEAR:      cur_cfg.near_weight    = data;
            default:                ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_random_config();
        logic [soc_pkg::K_W-1:0] kv;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
                0:       kv = 5'd0;
                1:       kv = 5'd1;
                2, 3:    kv = 5'd16;
                4:       kv = 5'($urandom_range(17, 31));
                default: kv = 5'($urandom_range(2, 16));
            endcase
            write_reg(soc_pkg::CFG_BIT_COUNT, {3'($urandom), kv});
        end
        if ($urandom_range(0, 3) != 0) write_reg(soc_pkg::CFG_CENTRAL, pick_weight());
        if ($urandom_range(0, 3) != 0) write_reg(soc_pkg::CFG_NEAR, pick_weight());
        if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 8'($urandom));
    endtask

    // Reset settings: no open sequence, bits above the width, all ones, zero
    task automatic test_reset_state();
        send_item(1'b0, 16'h0007);
        send_item(1'b0, 16'hFFC0);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b0, 16'h0000);
    endtask

    // Width above the maximum, top weights, chain grown to full depth
    task automatic test_long_chain();
        wait_drained();
        write_reg(soc_pkg::CFG_BIT_COUNT, 8'hFF);
        write_reg(soc_pkg::CFG_CENTRAL, 8'd255);
        write_reg(soc_pkg::CFG_NEAR, 8'd255);
        for (int i = 0; i < soc_pkg::MAX_BITS; i++) send_item(i == 0, 16'd1 << i);
        send_item(1'b0, 16'h0000);
    endtask

    // Zero width masks everything, zero weights
    task automatic test_zero_width();
        wait_drained();
        write_reg(soc_pkg::CFG_BIT_COUNT, 8'h00);
        write_reg(soc_pkg::CFG_CENTRAL, 8'd0);
        write_reg(soc_pkg::CFG_NEAR, 8'd0);
        send_item(1'b1, 16'hFFFF);
    endtask

    // Odd width, then a narrower width within the same sequence
    task automatic test_width_change();
        wait_drained();
        write_reg(soc_pkg::CFG_BIT_COUNT, 8'd5);
        write_reg(soc_pkg::CFG_CENTRAL, 8'd40);
        write_reg(soc_pkg::CFG_NEAR, 8'd3);
        send_item(1'b1, 16'h0013);
        wait_drained();
        write_reg(soc_pkg::CFG_BIT_COUNT, 8'd3);
        send_item(1'b0, 16'h00FC);
    endtask

    // Stall the output long enough to back up the input, then drain
    task automatic test_backpressure();
        wait_drained();
        write_reg(soc_pkg::CFG_BIT_COUNT, 8'd10);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_item(i == 0, pick_mask(10));
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_sequences();
        int left, seq_len;
        bit resume, start_seq;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            set_random_config();
            idle_on = (phase % 4 != 3);
            resume  = ($urandom_range(0, 2) == 0);
            left    = PHASE_ITEMS;
            while (left > 0) begin
                seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 20);
                for (int i = 0; i < seq_len && left > 0; i++) begin
                    // Break a sequence now and then
                    start_seq = (i == 0 && !resume) || ($urandom_range(0, 49) == 0);
                    send_item(start_seq, pick_mask(eff_width()));
                    left--;
                end
                resume = 1'b0;
            end
        end
        idle_on = 1'b1;
    endtask

    // Stall the output at random, or for one long hold when asked
    initial begin : out_stall_gen
        int run;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 15) begin
                run = pick_gap();
                i_out_stall <= 1'b1;
                repeat (run + 1) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        soc_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (score_queue.size() == 0) begin
                $error("result word with no item pending");
                fail_count++;
            end else begin
                want = score_queue.pop_front();
                if (o_out_word.running_score !== want.running_score) begin
                    $error("running_score: expected %0d, actual %0d",
                           want.running_score, o_out_word.running_score);
                    fail_count++;
                end
                if (o_out_word.chain_length !== want.chain_length) begin
                    $error("chain_length: expected %0d, actual %0d",
                           want.chain_length, o_out_word.chain_length);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_long_chain();
        test_zero_width();
        test_width_change();
        test_backpressure();
        test_random_sequences();
        wait_drained();
        if (fail_count == 0 && score_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
